// ===== hw/rtl/sfe_pkg.sv =====
// Shared types and constants of the symbol frequency estimator.
`default_nettype none

package sfe_pkg;

	// Default sizes for the top-level parameters.
	localparam int MAX_ALPHABET_DEF = 32;
	localparam int COUNT_BITS_DEF = 32;

	// Fraction bits of the frequency result (Q1.FRAC_BITS).
	localparam int FRAC_BITS = 16;

	// Fixed field widths.
	localparam int SYM_W = 8;
	localparam int IDX_W = 5;
	localparam int FREQ_W = FRAC_BITS + 1;
	localparam int ASZ_W = 6;

	// Alphabet size after reset.
	localparam logic [ASZ_W-1:0] ALPHA_RESET = 6'd4;

	typedef struct packed {
		logic [SYM_W-1:0] symbol;
		logic             last_symbol;
	} sym_item_t;

	typedef struct packed {
		logic [IDX_W-1:0]  symbol_index;
		logic [FREQ_W-1:0] frequency;
		logic              bad_symbol_seen;
		logic              last_result;
	} res_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sfe_count_mem.sv =====
// Occurrence count memory with read-modify-write increment and forwarding.
`default_nettype none

module sfe_count_mem #(
	parameter int MAX_ALPHABET = sfe_pkg::MAX_ALPHABET_DEF,
	parameter int COUNT_BITS = sfe_pkg::COUNT_BITS_DEF,
	localparam int AW = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  rd_en,
	input  wire logic [AW-1:0]         rd_addr,
	input  wire logic                  inc_en,
	input  wire logic                  clear_all,
	output logic      [COUNT_BITS-1:0] rd_data
);

	logic [COUNT_BITS-1:0] mem [MAX_ALPHABET];
	logic [MAX_ALPHABET-1:0] vld_q;

	logic [COUNT_BITS-1:0] rdata_s1;
	logic                  rvld_s1;
	logic [AW-1:0]         addr_s1;
	logic                  inc_s1;

	logic                  wr_valid_q;
	logic [AW-1:0]         wr_addr_q;
	logic [COUNT_BITS-1:0] wr_data_q;

	logic [COUNT_BITS-1:0] cur;
	logic [COUNT_BITS-1:0] cur_inc;

	// The read registered at the previous edge missed a write made at that same edge.
	always_comb begin
		if (wr_valid_q && (wr_addr_q == addr_s1)) begin
			cur = wr_data_q;
		end else if (rvld_s1) begin
			cur = rdata_s1;
		end else begin
			cur = '0;
		end
		cur_inc = (cur == {COUNT_BITS{1'b1}}) ? cur : cur + COUNT_BITS'(1);
	end

	assign rd_data = cur;

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rdata_s1 <= mem[rd_addr];
			addr_s1 <= rd_addr;
		end
		if (inc_s1) begin
			mem[addr_s1] <= cur_inc;
			wr_addr_q <= addr_s1;
			wr_data_q <= cur_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_s1 <= 1'b0;
			inc_s1 <= 1'b0;
			wr_valid_q <= 1'b0;
		end else begin
			if (rd_en) begin
				rvld_s1 <= vld_q[rd_addr];
			end
			inc_s1 <= rd_en && inc_en;
			wr_valid_q <= inc_s1 && !clear_all;
			if (clear_all) begin
				vld_q <= '0;
			end else if (inc_s1) begin
				vld_q[addr_s1] <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sfe_divider.sv =====
// Restoring divider that forms a count over the text length as a Q1.FRAC_BITS fraction.
`default_nettype none

module sfe_divider #(
	parameter int COUNT_BITS = sfe_pkg::COUNT_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	input  wire logic [COUNT_BITS-1:0]         num,
	input  wire logic [COUNT_BITS-1:0]         den,
	output logic                               done,
	output logic      [sfe_pkg::FREQ_W-1:0]    quot
);

	localparam int CW = $clog2(sfe_pkg::FRAC_BITS + 1);

	logic [COUNT_BITS-1:0]        rem_q;
	logic [COUNT_BITS-1:0]        den_q;
	logic [sfe_pkg::FREQ_W-1:0]   quot_q;
	logic [CW-1:0]                cnt_q;
	logic                         done_q;

	logic [COUNT_BITS:0]          rem_sh;
	logic                         fits;

	// The remainder stays below the divisor, so the shifted value needs one extra bit only.
	assign rem_sh = {rem_q, 1'b0};
	assign fits = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= num;
			den_q <= den;
			if (den == '0) begin
				quot_q <= '0;
			end else if (num >= den) begin
				quot_q <= sfe_pkg::FREQ_W'(1) << sfe_pkg::FRAC_BITS;
			end else begin
				quot_q <= '0;
			end
		end else if (cnt_q != '0) begin
			rem_q <= fits ? COUNT_BITS'(rem_sh - {1'b0, den_q}) : rem_sh[COUNT_BITS-1:0];
			quot_q <= {quot_q[sfe_pkg::FREQ_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			if ((den == '0) || (num >= den)) begin
				cnt_q <= '0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= CW'(sfe_pkg::FRAC_BITS);
				done_q <= 1'b0;
			end
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - CW'(1);
			done_q <= (cnt_q == CW'(1));
		end
	end

	assign done = done_q;
	assign quot = quot_q;

endmodule

`default_nettype wire

// ===== hw/rtl/symbol_frequency_estimator.sv =====
// Top level of the symbol frequency estimator: counting control and result output.
//
// Usage: symbol items arrive on the sym channel (valid/ready). Each item whose symbol
// lies below the alphabet size increments that symbol's count and the text length;
// any other symbol only sets a sticky error flag. While counting, the block takes
// one item per cycle: the count memory is read at acceptance and written back in the
// following cycle, with the last write forwarded to a read of the same entry.
// The item flagged last_symbol ends the text. The block then stops taking items and
// emits one result per alphabet symbol, in ascending order, on the res channel.
// Each result passes through a memory read, the divider load, the restoring divider
// at one quotient bit per cycle, and the result hand-off; the divider skips its bits
// when the length is zero or the count reaches the length.
// The final result carries last_result. Once it is loaded into the output register
// the counts, length and error flag are cleared and new items are taken again, even
// while that result still waits for the receiver. A stalled receiver simply holds
// the block before the next result. Reset clears all counts, the length and the
// error flag at once, and sets the alphabet size to 4. The cfg port writes the
// alphabet size; write it only while no text is in progress.
`default_nettype none

module symbol_frequency_estimator #(
	parameter int MAX_ALPHABET = sfe_pkg::MAX_ALPHABET_DEF,
	parameter int COUNT_BITS = sfe_pkg::COUNT_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       sym_valid,
	output logic                            sym_ready,
	input  wire sfe_pkg::sym_item_t         sym_item,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output sfe_pkg::res_item_t              res_item,
	input  wire logic                       cfg_we,
	input  wire logic [sfe_pkg::ASZ_W-1:0]  cfg_wdata
);

	localparam int AW = (MAX_ALPHABET > 1) ? $clog2(MAX_ALPHABET) : 1;
	localparam int NW = $clog2(MAX_ALPHABET + 1);

	typedef enum logic [3:0] {
		S_COUNT = 4'b0001,
		S_READ  = 4'b0010,
		S_LOAD  = 4'b0100,
		S_DIV   = 4'b1000
	} state_t;

	state_t state_q;

	logic [sfe_pkg::ASZ_W-1:0] alpha_q;
	logic [NW-1:0]             n_eff;
	logic [COUNT_BITS-1:0]     len_q;
	logic                      err_q;
	logic [AW-1:0]             k_q;

	logic                      sym_acc;
	logic                      sym_ok;
	logic                      k_last;
	logic                      res_load;

	logic                      mem_rd_en;
	logic [AW-1:0]             mem_rd_addr;
	logic                      mem_clear;
	logic [COUNT_BITS-1:0]     mem_rd_data;

	logic                      div_start;
	logic                      div_done;
	logic [sfe_pkg::FREQ_W-1:0] div_quot;

	logic                      res_valid_q;
	sfe_pkg::res_item_t        res_item_q;

	// Effective alphabet size: the register clamped to 1..MAX_ALPHABET.
	always_comb begin
		if (alpha_q == '0) begin
			n_eff = NW'(1);
		end else if (int'(alpha_q) > MAX_ALPHABET) begin
			n_eff = NW'(MAX_ALPHABET);
		end else begin
			n_eff = NW'(alpha_q);
		end
	end

	assign sym_ready = (state_q == S_COUNT);
	assign sym_acc = sym_valid && sym_ready;
	assign sym_ok = (16'(sym_item.symbol) < 16'(n_eff));
	assign k_last = ((NW'(k_q) + NW'(1)) == n_eff);

	// The output register may take a new result when it is empty or being drained.
	assign res_load = (state_q == S_DIV) && div_done && (!res_valid_q || res_ready);

	// Counting reads the entry of the arriving symbol; the result pass reads entry k.
	assign mem_rd_en = sym_acc || (state_q == S_READ);
	assign mem_rd_addr = (state_q == S_COUNT) ? sym_item.symbol[AW-1:0] : k_q;
	assign mem_clear = res_load && k_last;

	assign div_start = (state_q == S_LOAD);

	sfe_count_mem #(
		.MAX_ALPHABET(MAX_ALPHABET),
		.COUNT_BITS(COUNT_BITS)
	) u_mem (
		.clk(clk),
		.arst_n(arst_n),
		.rd_en(mem_rd_en),
		.rd_addr(mem_rd_addr),
		.inc_en(sym_acc && sym_ok),
		.clear_all(mem_clear),
		.rd_data(mem_rd_data)
	);

	sfe_divider #(
		.COUNT_BITS(COUNT_BITS)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.num(mem_rd_data),
		.den(len_q),
		.done(div_done),
		.quot(div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_COUNT;
			alpha_q <= sfe_pkg::ALPHA_RESET;
			len_q <= '0;
			err_q <= 1'b0;
			k_q <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				alpha_q <= cfg_wdata;
			end

			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (res_ready) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_COUNT: begin
					if (sym_acc) begin
						if (sym_ok) begin
							if (len_q != {COUNT_BITS{1'b1}}) begin
								len_q <= len_q + COUNT_BITS'(1);
							end
						end else begin
							err_q <= 1'b1;
						end
						if (sym_item.last_symbol) begin
							k_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: begin
					state_q <= S_LOAD;
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (res_load) begin
						if (k_last) begin
							// End of the text: start afresh for the next one.
							len_q <= '0;
							err_q <= 1'b0;
							state_q <= S_COUNT;
						end else begin
							k_q <= k_q + AW'(1);
							state_q <= S_READ;
						end
					end
				end
				default: begin
					state_q <= S_COUNT;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_item_q.symbol_index <= sfe_pkg::IDX_W'(k_q);
			res_item_q.frequency <= div_quot;
			res_item_q.bad_symbol_seen <= err_q;
			res_item_q.last_result <= k_last;
		end
	end

	assign res_valid = res_valid_q;
	assign res_item = res_item_q;

endmodule

`default_nettype wire

// ===== tb/sfe_freq_checker.sv =====
// Checker for the symbol frequency estimator: predicts frequency results and compares them.
`timescale 1ns / 1ps

module sfe_freq_checker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     sym_valid,
	input  logic                     sym_ready,
	input  sfe_pkg::sym_item_t       sym_item,
	input  logic                     res_valid,
	input  logic                     res_ready,
	input  sfe_pkg::res_item_t       res_item,
	input  logic                     cfg_we,
	input  logic [sfe_pkg::ASZ_W-1:0] cfg_wdata,
	output int                       fail_count,
	output int                       expected_left,
	output int                       freqs_checked,
	output int                       texts_closed
);
	import sfe_pkg::*;

	localparam int ALPHA_MAX = MAX_ALPHABET_DEF;
	localparam logic [COUNT_BITS_DEF-1:0] COUNT_SAT = '1;

	logic [COUNT_BITS_DEF-1:0] sym_counts [ALPHA_MAX];
	logic [COUNT_BITS_DEF-1:0] text_len;
	logic                      bad_seen;
	logic [ASZ_W-1:0]          alpha_reg;
	res_item_t                 freq_results_due [$];

	// Sizes of 0 act as 1, sizes beyond the counter array act as the full array.
	function automatic int active_symbols(input logic [ASZ_W-1:0] a);
		if (a == 0)
			return 1;
		if (int'(a) > ALPHA_MAX)
			return ALPHA_MAX;
		return int'(a);
	endfunction

	// Truncated count / length as a Q1.16 fraction; a full count gives exactly 1.0.
	function automatic logic [FREQ_W-1:0] relative_freq(input logic [COUNT_BITS_DEF-1:0] c,
			input logic [COUNT_BITS_DEF-1:0] len);
		logic [63:0] q;
		if (len == 0)
			return '0;
		if (c >= len)
			return FREQ_W'(1) << FRAC_BITS;
		q = ({32'd0, c} << FRAC_BITS) / {32'd0, len};
		return q[FREQ_W-1:0];
	endfunction

	task automatic clear_text();
		for (int i = 0; i < ALPHA_MAX; i++)
			sym_counts[i] = '0;
		text_len = '0;
		bad_seen = 1'b0;
	endtask

	task automatic count_symbol(input sym_item_t it);
		int n;
		res_item_t r;
		n = active_symbols(alpha_reg);
		if (int'(it.symbol) < n) begin
			if (sym_counts[it.symbol] != COUNT_SAT)
				sym_counts[it.symbol] = sym_counts[it.symbol] + 1'b1;
			if (text_len != COUNT_SAT)
				text_len = text_len + 1'b1;
		end else begin
			bad_seen = 1'b1;
		end
		if (it.last_symbol) begin
			for (int k = 0; k < n; k++) begin
				r.symbol_index = IDX_W'(k);
				r.frequency = relative_freq(sym_counts[k], text_len);
				r.bad_symbol_seen = bad_seen;
				r.last_result = (k == n - 1);
				freq_results_due.push_back(r);
			end
			clear_text();
			texts_closed++;
		end
	endtask

	task automatic report_mismatch(input string what, input res_item_t got,
			input res_item_t want);
		string got_s;
		string want_s;
		got_s = $sformatf("idx=%0d freq=%0d bad=%0d last=%0d", got.symbol_index,
			got.frequency, got.bad_symbol_seen, got.last_result);
		want_s = $sformatf("idx=%0d freq=%0d bad=%0d last=%0d", want.symbol_index,
			want.frequency, want.bad_symbol_seen, want.last_result);
		$display("%0t ns: result mismatch (%s): got %s, want %s", $time, what, got_s, want_s);
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		res_item_t want;
		string diff;
		if (!arst_n) begin
			clear_text();
			alpha_reg = ALPHA_RESET;
			freq_results_due.delete();
		end else begin
			if (cfg_we)
				alpha_reg = cfg_wdata;
			if (sym_valid && sym_ready)
				count_symbol(sym_item);
			if (res_valid && res_ready) begin
				if (freq_results_due.size() == 0) begin
					report_mismatch("no result due", res_item, '0);
				end else begin
					want = freq_results_due.pop_front();
					diff = "";
					if (res_item.symbol_index !== want.symbol_index)
						diff = {diff, " symbol_index"};
					if (res_item.frequency !== want.frequency)
						diff = {diff, " frequency"};
					if (res_item.bad_symbol_seen !== want.bad_symbol_seen)
						diff = {diff, " bad_symbol_seen"};
					if (res_item.last_result !== want.last_result)
						diff = {diff, " last_result"};
					if (diff != "")
						report_mismatch(diff, res_item, want);
					freqs_checked++;
				end
			end
		end
		expected_left = freq_results_due.size();
	end

endmodule

// ===== tb/testbench.sv =====
// Top of the symbol frequency estimator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
	import sfe_pkg::*;

	logic             clk;
	logic             arst_n;
	logic             sym_valid;
	logic             sym_ready;
	sym_item_t        sym_item;
	logic             res_valid;
	logic             res_ready;
	res_item_t        res_item;
	logic             cfg_we;
	logic [ASZ_W-1:0] cfg_wdata;

	// Status handed up by the checker.
	int fail_count;
	int expected_left;
	int freqs_checked;
	int texts_closed;

	// Pacing knobs, in percent of cycles, and stimulus bookkeeping.
	int send_idle;
	int recv_stall;
	int items_sent;
	int active_n;

	symbol_frequency_estimator u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sym_valid (sym_valid),
		.sym_ready (sym_ready),
		.sym_item  (sym_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sfe_freq_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.sym_valid     (sym_valid),
		.sym_ready     (sym_ready),
		.sym_item      (sym_item),
		.res_valid     (res_valid),
		.res_ready     (res_ready),
		.res_item      (res_item),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.fail_count    (fail_count),
		.expected_left (expected_left),
		.freqs_checked (freqs_checked),
		.texts_closed  (texts_closed)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// The receiver decides at each falling edge whether it stalls during the next cycle.
	initial begin
		res_ready = 1'b0;
		forever begin
			@(negedge clk);
			res_ready <= ($urandom_range(0, 99) >= recv_stall);
		end
	end

	// Watchdog. It is sized far above the slowest legal run: every item closing a text
	// of 32 results, each through the full division, with heavy receiver stalls on top.
	initial begin
		#40_000_000;
		$display("Timeout with %0d results still due.", expected_left);
		$display("Simulation FAILED");
		$finish;
	end

	// All driving tasks are entered just after a falling edge and return just after one.

	// Offers one item, possibly after some idle cycles, and waits for the handshake.
	// Valid is left high on return so that back-to-back items keep it high.
	task automatic send_symbol(input logic [SYM_W-1:0] s, input logic last);
		while ($urandom_range(0, 99) < send_idle) begin
			sym_valid <= 1'b0;
			@(negedge clk);
		end
		sym_valid <= 1'b1;
		sym_item <= '{symbol: s, last_symbol: last};
		do
			@(posedge clk);
		while (!sym_ready);
		items_sent++;
		@(negedge clk);
	endtask

	// Stops offering items and waits until every due result has been taken. The
	// extra cycles let the count write-back settle before a register write.
	task automatic wait_drained();
		sym_valid <= 1'b0;
		while (expected_left != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// Single-cycle register write; the block must be idle when this is called.
	task automatic write_alphabet(input logic [ASZ_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		active_n = (v == 0) ? 1 : ((int'(v) > MAX_ALPHABET_DEF) ? MAX_ALPHABET_DEF : int'(v));
	endtask

	// One text of len items; the final one carries the last flag. Symbols are drawn
	// from the active alphabet except for a share of arbitrary codes.
	task automatic send_text(input int len, input int bad_pct);
		logic [SYM_W-1:0] s;
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 99) < bad_pct)
				s = SYM_W'($urandom_range(0, 255));
			else
				s = SYM_W'($urandom_range(0, active_n - 1));
			send_symbol(s, i == len - 1);
		end
	endtask

	// A random phase with one pacing mix, split into two alphabet settings. Texts are
	// mostly short with in-alphabet symbols; some are long, some carry many bad codes,
	// and a few draw arbitrary codes only, which can make them empty texts.
	task automatic run_random_phase(input int idle_pct, input int stall_pct, input int goal);
		int start;
		int len;
		int bad_pct;
		logic [ASZ_W-1:0] a;
		for (int blk = 0; blk < 2; blk++) begin
			wait_drained();
			send_idle = idle_pct;
			recv_stall = stall_pct;
			// Mostly small alphabets keep the result bursts short.
			if ($urandom_range(0, 3) == 0)
				a = ASZ_W'($urandom_range(0, 63));
			else
				a = ASZ_W'($urandom_range(1, 8));
			write_alphabet(a);
			start = items_sent;
			while (items_sent - start < goal / 2) begin
				if ($urandom_range(0, 9) == 0)
					len = $urandom_range(13, 40);
				else
					len = $urandom_range(1, 12);
				case ($urandom_range(0, 19))
					0: bad_pct = 100;
					1, 2, 3, 4: bad_pct = 30;
					default: bad_pct = 3;
				endcase
				send_text(len, bad_pct);
				// Now and then the sender holds off until the block has drained.
				if ($urandom_range(0, 15) == 0)
					wait_drained();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sym_valid = 1'b0;
		sym_item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		send_idle = 0;
		recv_stall = 0;
		items_sent = 0;
		active_n = int'(ALPHA_RESET);
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed part. The alphabet size after reset is used first, unwritten.
		// Mixed counts with truncated fractions, plus two codes just past the
		// alphabet and at the top of the symbol range.
		send_symbol(8'd0, 1'b0);
		send_symbol(8'd1, 1'b0);
		send_symbol(8'd2, 1'b0);
		send_symbol(8'd3, 1'b0);
		send_symbol(8'd3, 1'b0);
		send_symbol(8'd255, 1'b0);
		send_symbol(8'd4, 1'b0);
		send_symbol(8'd3, 1'b1);
		// A single-symbol text gives full scale for that symbol.
		send_symbol(8'd2, 1'b1);
		// A text with no accepted symbol gives all-zero frequencies and the error flag.
		send_symbol(8'd200, 1'b1);
		wait_drained();

		// A size of zero behaves as one.
		write_alphabet(6'd0);
		send_symbol(8'd0, 1'b0);
		send_symbol(8'd1, 1'b0);
		send_symbol(8'd0, 1'b1);
		wait_drained();
		write_alphabet(6'd1);
		send_symbol(8'd0, 1'b1);
		wait_drained();

		// Oversized settings clamp to the full alphabet.
		write_alphabet(6'd63);
		send_symbol(8'd31, 1'b0);
		send_symbol(8'd32, 1'b0);
		send_symbol(8'd0, 1'b1);
		wait_drained();
		write_alphabet(6'd32);
		send_symbol(8'd17, 1'b0);
		send_symbol(8'd128, 1'b0);
		send_symbol(8'd5, 1'b1);
		wait_drained();
		write_alphabet(6'd33);
		send_symbol(8'd31, 1'b1);

		// Random part: no idling, a slow sender, a slow receiver, then light idling on both.
		run_random_phase(0, 0, 100);
		run_random_phase(76, 0, 100);
		run_random_phase(0, 76, 100);
		run_random_phase(8, 8, 100);

		// Let the last burst drain, then leave room for any stray result.
		wait_drained();
		repeat (40) @(negedge clk);

		$display("Sent %0d symbol items in %0d texts; %0d frequency results were compared.",
			items_sent, texts_closed, freqs_checked);
		$display("Alphabet sizes from 0 to 63, bad codes, empty texts and four pacing mixes ran.");
		if (fail_count == 0 && expected_left == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== symbol_frequency_estimator.f =====
hw/rtl/sfe_pkg.sv
hw/rtl/sfe_count_mem.sv
hw/rtl/sfe_divider.sv
hw/rtl/symbol_frequency_estimator.sv
tb/sfe_freq_checker.sv
tb/testbench.sv
